// ===== rtl/core/wvp_pkg.sv =====
// wave variable predictor package: widths, register indexes, operation codes,
// the multiply-accumulate program table and the saturation helper
// no dependencies
package wvp_pkg;

   localparam int DATA_W = 32;
   localparam int CFG_W = 31;
   localparam int AXIS_W = 2;
   localparam int DEF_DELAY_DEPTH = 8;
   localparam int DEF_AXES = 3;
   localparam int SUM_W = 34;
   localparam int OPND_W = 34;
   localparam int PROD_W = 68;
   localparam int ACC_W = 68;
   localparam int NUM_W = 64;
   localparam int OP_W = 5;
   localparam int NUM_OPS = 22;
   localparam int TAP_W = 3;
   localparam int RATIO_MIN = 65536;

   // configuration register indexes
   localparam logic [AXIS_W-1:0] CSR_DAMPING = 2'd0;
   localparam logic [AXIS_W-1:0] CSR_ROOT = 2'd1;
   localparam logic [AXIS_W-1:0] CSR_RATIO = 2'd2;

   // coefficient side sources
   localparam logic [1:0] ASRC_ROOT = 2'd0;
   localparam logic [1:0] ASRC_DAMP = 2'd1;
   localparam logic [1:0] ASRC_CONST = 2'd2;

   // data side sources
   localparam logic [3:0] BSRC_VEL = 4'd0;
   localparam logic [3:0] BSRC_WAVE = 4'd1;
   localparam logic [3:0] BSRC_PD = 4'd2;
   localparam logic [3:0] BSRC_PM = 4'd3;
   localparam logic [3:0] BSRC_VM = 4'd4;
   localparam logic [3:0] BSRC_S0 = 4'd5;
   localparam logic [3:0] BSRC_S1 = 4'd6;
   localparam logic [3:0] BSRC_X0 = 4'd7;
   localparam logic [3:0] BSRC_X1 = 4'd8;
   localparam logic [3:0] BSRC_X2 = 4'd9;
   localparam logic [3:0] BSRC_ROW0 = 4'd10;

   // accumulator operations
   localparam logic [1:0] ACC_LOAD = 2'd0;
   localparam logic [1:0] ACC_ADD = 2'd1;
   localparam logic [1:0] ACC_SUB = 2'd2;

   // post-accumulate actions
   localparam logic [2:0] CMT_NONE = 3'd0;
   localparam logic [2:0] CMT_WAVE = 3'd1;
   localparam logic [2:0] CMT_NUM = 3'd2;
   localparam logic [2:0] CMT_SHIFT = 3'd3;
   localparam logic [2:0] CMT_X = 3'd4;
   localparam logic [2:0] CMT_PRED = 3'd5;

   typedef struct packed {
      logic [1:0]  a_src;
      logic [31:0] coef;
      logic [3:0]  b_src;
      logic [1:0]  acc_op;
      logic [2:0]  cmt;
      logic [1:0]  x_idx;
   } op_type;

   typedef struct packed {
      logic            load_item;
      logic            sum_en;
      logic [TAP_W-1:0] sum_idx;
      logic            mul_en;
      logic            acc_en;
      logic            cmt_en;
      logic            out_load;
      op_type          op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic op_type mk_op(input logic [1:0] a_src, input logic [31:0] coef,
                                    input logic [3:0] b_src, input logic [1:0] acc_op,
                                    input logic [2:0] cmt, input logic [1:0] x_idx);
      op_type o;
      o.a_src = a_src;
      o.coef = coef;
      o.b_src = b_src;
      o.acc_op = acc_op;
      o.cmt = cmt;
      o.x_idx = x_idx;
      return o;
   endfunction

   // program: wave, force numerator, three state rows, output row
   function automatic op_type op_table(input logic [OP_W-1:0] u);
      op_type o;
      case (u)
         5'd0:  o = mk_op(ASRC_ROOT, 32'sd0, BSRC_VEL, ACC_LOAD, CMT_WAVE, 2'd0);
         5'd1:  o = mk_op(ASRC_ROOT, 32'sd0, BSRC_WAVE, ACC_LOAD, CMT_NONE, 2'd0);
         5'd2:  o = mk_op(ASRC_DAMP, 32'sd0, BSRC_VEL, ACC_SUB, CMT_NUM, 2'd0);
         5'd3:  o = mk_op(ASRC_CONST, 32'sd26942419, BSRC_S0, ACC_LOAD, CMT_NONE, 2'd0);
         5'd4:  o = mk_op(ASRC_CONST, 32'sd26368793, BSRC_S1, ACC_ADD, CMT_SHIFT, 2'd0);
         5'd5:  o = mk_op(ASRC_CONST, 32'sd15900309, BSRC_PD, ACC_ADD, CMT_NONE, 2'd0);
         5'd6:  o = mk_op(ASRC_CONST, 32'sd876907, BSRC_PM, ACC_ADD, CMT_NONE, 2'd0);
         5'd7:  o = mk_op(ASRC_CONST, 32'sd26199, BSRC_VM, ACC_ADD, CMT_X, 2'd0);
         5'd8:  o = mk_op(ASRC_CONST, 32'sd173981, BSRC_S0, ACC_LOAD, CMT_NONE, 2'd1);
         5'd9:  o = mk_op(ASRC_CONST, 32'sd349029, BSRC_S1, ACC_ADD, CMT_SHIFT, 2'd1);
         5'd10: o = mk_op(ASRC_CONST, 32'sd1609, BSRC_PD, ACC_ADD, CMT_NONE, 2'd1);
         5'd11: o = mk_op(ASRC_CONST, 32'sd16775606, BSRC_PM, ACC_ADD, CMT_NONE, 2'd1);
         5'd12: o = mk_op(ASRC_CONST, 32'sd33507, BSRC_VM, ACC_ADD, CMT_X, 2'd1);
         5'd13: o = mk_op(ASRC_CONST, 32'sd174521305, BSRC_S0, ACC_LOAD, CMT_NONE, 2'd2);
         5'd14: o = mk_op(ASRC_CONST, 32'sd175564258, BSRC_S1, ACC_ADD, CMT_SHIFT, 2'd2);
         5'd15: o = mk_op(ASRC_CONST, 32'sd1594377, BSRC_PD, ACC_ADD, CMT_NONE, 2'd2);
         5'd16: o = mk_op(ASRC_CONST, -32'sd1594377, BSRC_PM, ACC_ADD, CMT_NONE, 2'd2);
         5'd17: o = mk_op(ASRC_CONST, 32'sd16729581, BSRC_VM, ACC_ADD, CMT_X, 2'd2);
         5'd18: o = mk_op(ASRC_CONST, -32'sd126055583, BSRC_X0, ACC_LOAD, CMT_NONE, 2'd0);
         5'd19: o = mk_op(ASRC_CONST, 32'sd126055583, BSRC_X1, ACC_ADD, CMT_NONE, 2'd0);
         5'd20: o = mk_op(ASRC_CONST, 32'sd3638911, BSRC_X2, ACC_ADD, CMT_NONE, 2'd0);
         5'd21: o = mk_op(ASRC_CONST, -32'sd578795, BSRC_ROW0, ACC_ADD, CMT_PRED, 2'd0);
         default: o = mk_op(ASRC_CONST, 32'sd0, BSRC_VEL, ACC_LOAD, CMT_NONE, 2'd0);
      endcase
      return o;
   endfunction

   // clamp a wide signed value to 32 bits
   function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
      logic fits;
      fits = (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
      if (fits) return v[DATA_W-1:0];
      else if (v[ACC_W-1]) return 32'h8000_0000;
      else return 32'h7FFF_FFFF;
   endfunction

endpackage

// ===== rtl/core/wvp_div.sv =====
// bit-serial signed by unsigned divider for the force term, truncating, saturated
// depends on wvp_pkg
module wvp_div
   import wvp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [CFG_W-1:0]  den,
   output logic              busy,
   output logic [DATA_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] trial;
   logic [NUM_W-1:0]  qneg;
   logic [ACC_W-1:0]  qsigned;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      trial = {rem_ff[DATA_W-2:0], q_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(NUM_W);
         neg_in = num[NUM_W-1];
         q_in = num[NUM_W-1] ? (~num + 1'b1) : num;
         rem_in = '0;
         den_in = (den < CFG_W'(RATIO_MIN)) ? CFG_W'(RATIO_MIN) : den;
      end else if (busy_ff) begin
         q_in = {q_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // apply sign and clamp
   assign qneg = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign qsigned = {{(ACC_W-NUM_W){qneg[NUM_W-1] & (q_ff != '0)}}, qneg};
   assign quot = sat32(qsigned);
   assign busy = busy_ff;

endmodule

// ===== rtl/core/wvp_datapath.sv =====
// datapath: item registers, delay line, shared multiplier and accumulator,
// force divider and result registers; depends on wvp_pkg and wvp_div
module wvp_datapath
   import wvp_pkg::*;
#(
   parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
   parameter int AXES = DEF_AXES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [5*DATA_W-1:0]   req_tdata,
   input  logic [AXIS_W-1:0]     req_tuser,
   output logic [3*DATA_W-1:0]   rsp_tdata,
   output logic [AXIS_W-1:0]     rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [AXIS_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int RW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int DW = $clog2(DELAY_DEPTH);
   localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(1) << 15;
   localparam logic signed [ACC_W-1:0] RND20 = ACC_W'(1) << 19;
   localparam logic signed [ACC_W-1:0] RND24 = ACC_W'(1) << 23;

   // configuration registers
   logic [CFG_W-1:0] damp_ff, root_ff, ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff <= CFG_W'(655360);
         root_ff <= CFG_W'(293089);
         ratio_ff <= CFG_W'(327680);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DAMPING: damp_ff <= csr_wdata;
            CSR_ROOT:    root_ff <= csr_wdata;
            CSR_RATIO:   ratio_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // item registers
   logic [AXIS_W-1:0]        axis_ff;
   logic signed [DATA_W-1:0] vel_ff, win_ff, pd_ff, pm_ff, vm_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         axis_ff <= req_tuser;
         vel_ff <= req_tdata[DATA_W-1:0];
         win_ff <= req_tdata[2*DATA_W-1:DATA_W];
         pd_ff <= req_tdata[3*DATA_W-1:2*DATA_W];
         pm_ff <= req_tdata[4*DATA_W-1:3*DATA_W];
         vm_ff <= req_tdata[5*DATA_W-1:4*DATA_W];
      end
   end

   // row select
   logic [RW+AXIS_W-1:0] axis_ext;
   logic [RW-1:0]        row_idx;
   logic                 row_ok;

   assign axis_ext = {{RW{1'b0}}, axis_ff};
   assign row_idx = axis_ext[RW-1:0];
   assign row_ok = (axis_ext < (RW+AXIS_W)'(AXES));

   // delay line, newest entry at tap zero
   logic signed [DATA_W-1:0] line_ff [AXES][DELAY_DEPTH];
   logic signed [DATA_W-1:0] wave_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < AXES; r++)
            for (int i = 0; i < DELAY_DEPTH; i++)
               line_ff[r][i] <= '0;
      end else if (cmd.out_load && row_ok) begin
         for (int i = DELAY_DEPTH - 1; i > 0; i--)
            line_ff[row_idx][i] <= line_ff[row_idx][i-1];
         line_ff[row_idx][0] <= wave_ff;
      end
   end

   // tap sums, one tap per cycle
   logic signed [SUM_W-1:0]  s0_ff, s1_ff;
   logic signed [DATA_W-1:0] row0_ff, tap_val;
   logic [DW-1:0]            tap_idx;

   assign tap_idx = DW'(cmd.sum_idx);
   assign tap_val = row_ok ? line_ff[row_idx][tap_idx] : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         s0_ff <= '0;
         s1_ff <= '0;
      end else if (cmd.sum_en) begin
         if (cmd.sum_idx[TAP_W-1]) s1_ff <= s1_ff + SUM_W'(tap_val);
         else s0_ff <= s0_ff + SUM_W'(tap_val);
         if (cmd.sum_idx == '0) row0_ff <= tap_val;
      end
   end

   // operand select
   logic signed [DATA_W-1:0] x_ff [3];
   logic signed [OPND_W-1:0] a_opnd, b_opnd;

   always_comb begin
      case (cmd.op.a_src)
         ASRC_ROOT: a_opnd = {{(OPND_W-CFG_W){1'b0}}, root_ff};
         ASRC_DAMP: a_opnd = {{(OPND_W-CFG_W){1'b0}}, damp_ff};
         default:   a_opnd = {{(OPND_W-DATA_W){cmd.op.coef[DATA_W-1]}}, cmd.op.coef};
      endcase
      case (cmd.op.b_src)
         BSRC_VEL:  b_opnd = OPND_W'(vel_ff);
         BSRC_WAVE: b_opnd = OPND_W'(win_ff);
         BSRC_PD:   b_opnd = OPND_W'(pd_ff);
         BSRC_PM:   b_opnd = OPND_W'(pm_ff);
         BSRC_VM:   b_opnd = OPND_W'(vm_ff);
         BSRC_S0:   b_opnd = OPND_W'(s0_ff);
         BSRC_S1:   b_opnd = OPND_W'(s1_ff);
         BSRC_X0:   b_opnd = OPND_W'(x_ff[0]);
         BSRC_X1:   b_opnd = OPND_W'(x_ff[1]);
         BSRC_X2:   b_opnd = OPND_W'(x_ff[2]);
         BSRC_ROW0: b_opnd = OPND_W'(row0_ff);
         default:   b_opnd = '0;
      endcase
   end

   // shared multiplier, registered product
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= a_opnd * b_opnd;
   end

   // accumulator and post-accumulate actions
   logic signed [ACC_W-1:0] acc_ff, acc_base, prod_t, acc_r16, acc_r20, acc_r24, wave_t;
   logic signed [DATA_W-1:0] pred_ff;

   assign prod_t = prod_ff[ACC_W-1:0];
   assign acc_base = (cmd.op.acc_op == ACC_LOAD) ? '0 : acc_ff;
   assign acc_r16 = (acc_ff + RND16) >>> 16;
   assign acc_r20 = (acc_ff + RND20) >>> 20;
   assign acc_r24 = (acc_ff + RND24) >>> 24;
   assign wave_t = acc_r16 - ACC_W'(win_ff);

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         if (cmd.op.acc_op == ACC_SUB) acc_ff <= acc_base - prod_t;
         else acc_ff <= acc_base + prod_t;
      end else if (cmd.cmt_en) begin
         case (cmd.op.cmt)
            CMT_WAVE:  wave_ff <= sat32(wave_t);
            CMT_SHIFT: acc_ff <= acc_ff >>> 16;
            CMT_X:     x_ff[cmd.op.x_idx] <= sat32(acc_r24);
            CMT_PRED:  pred_ff <= sat32(acc_r20);
            default:   ;
         endcase
      end
   end

   // force divider
   logic              div_start, div_busy;
   logic [DATA_W-1:0] div_quot;

   assign div_start = cmd.cmt_en && (cmd.op.cmt == CMT_NUM);

   wvp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff[NUM_W-1:0]),
      .den   (ratio_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign status.div_busy = div_busy;

   // result registers
   logic [3*DATA_W-1:0] rsp_data_ff;
   logic [AXIS_W-1:0]   rsp_axis_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {pred_ff, wave_ff, div_quot};
         rsp_axis_ff <= axis_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_axis_ff;

endmodule

// ===== rtl/core/wvp_ctrl.sv =====
// controller: sequences tap summing, the multiply-accumulate program,
// the divider wait and the result hand-off; depends on wvp_pkg
module wvp_ctrl
   import wvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM = 3'd1;
   localparam logic [2:0] S_MUL = 3'd2;
   localparam logic [2:0] S_ACC = 3'd3;
   localparam logic [2:0] S_CMT = 3'd4;
   localparam logic [2:0] S_DIV = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [OP_W-1:0]  u_ff, u_in;
   logic             vld_ff, vld_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      tap_in = tap_ff;
      u_in = u_ff;
      cmd = '0;
      cmd.op = op_table(u_ff);
      cmd.sum_idx = tap_ff;
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               tap_in = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == '1) begin
               u_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (cmd.op.cmt != CMT_NONE) begin
               state_in = S_CMT;
            end else begin
               u_in = u_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_CMT: begin
            cmd.cmt_en = 1'b1;
            u_in = u_ff + 1'b1;
            if (u_ff == OP_W'(NUM_OPS - 1)) state_in = S_DIV;
            else state_in = S_MUL;
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // result valid flag
      if (cmd.out_load) vld_in = 1'b1;
      else if (rsp_tready) vld_in = 1'b0;
      else vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tap_ff <= '0;
         u_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff <= tap_in;
         u_ff <= u_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;

endmodule

// ===== rtl/core/wave_variable_predictor.sv =====
// Wave-variable interface with wave prediction, one axis sample per word. Each
// accepted word first has its axis delay taps summed, then one shared 34x34
// multiplier runs a 22-step multiply-accumulate program, while the force
// division, started when the program commits the force numerator, runs
// bit-serially beside it; the result waits for that divider to finish. One word
// is processed at a time: a new word is taken only after the previous result has
// been loaded into the output register, where it waits while the next word is
// taken; a new result that is ready while an earlier one is still held there
// waits until that one is taken.
// The delay line is cleared at reset; force_ratio below one is used as one.
// top level; depends on wvp_pkg, wvp_ctrl, wvp_datapath
module wave_variable_predictor
   import wvp_pkg::*;
#(
   parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
   parameter int AXES = DEF_AXES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // ee_velocity, incoming_wave, desired_pos, measured_pos, measured_vel
   input  logic [5*DATA_W-1:0] req_tdata,
   // axis
   input  logic [AXIS_W-1:0]   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // force_res, outgoing_wave, wave_forecast
   output logic [3*DATA_W-1:0] rsp_tdata,
   // axis_out
   output logic [AXIS_W-1:0]   rsp_tuser,
   input  logic                csr_wr_en,
   input  logic [AXIS_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   wvp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wvp_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .AXES        (AXES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== tb/sv/tb_wave_variable_predictor.sv =====
`timescale 1ns / 100ps
// self-checking testbench for wave_variable_predictor: directed table, then
// randomized words under several register settings, checked against table entries or a local model
// depends on wvp_pkg and the wave_variable_predictor rtl
module tb_wave_variable_predictor;
   import wvp_pkg::*;

   localparam int DEPTH = 8;
   localparam int NAXES = 3;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 120;
   localparam int DIR_ROWS = 14;
   localparam int MAX_I = 2147483647;
   localparam int MIN_I = -2147483648;

   // fixed state model coefficients (a in q.24, b gains in q.40, c and d in q.20)
   localparam longint MAT_A [0:2][0:2] = '{'{64'sd15900309, 64'sd876907, 64'sd26199},
                                           '{64'sd1609, 64'sd16775606, 64'sd33507},
                                           '{64'sd1594377, -64'sd1594377, 64'sd16729581}};
   localparam longint GAIN_B0 [0:2] = '{64'sd26942419, 64'sd173981, 64'sd174521305};
   localparam longint GAIN_B1 [0:2] = '{64'sd26368793, 64'sd349029, 64'sd175564258};
   localparam longint OUT_C [0:2] = '{-64'sd126055583, 64'sd126055583, 64'sd3638911};
   localparam longint OUT_D = -64'sd578795;

   typedef struct {
      logic [1:0] axis;
      int         force_v;
      int         wave_v;
      int         pred_v;
   } wave_result_type;

   typedef struct {
      bit         typed;
      logic [1:0] axis;
      int         vel;
      int         wave_in;
      int         pd;
      int         pm;
      int         vm;
      int         e_force;
      int         e_wave;
      int         e_pred;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [5*DATA_W-1:0] req_tdata;
   logic [AXIS_W-1:0]   req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [3*DATA_W-1:0] rsp_tdata;
   logic [AXIS_W-1:0]   rsp_tuser;
   logic                csr_wr_en;
   logic [AXIS_W-1:0]   csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   // model state and register copies
   int                  wave_hist [0:NAXES-1][0:DEPTH-1];
   logic [30:0]         m_damping;
   logic [30:0]         m_root;
   logic [30:0]         m_ratio;
   wave_result_type     pending_results[$];
   int                  errors;
   int                  idle_cycles;
   int                  rsp_stall;
   bit                  no_idle;

   wave_variable_predictor u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint round_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return MAX_I;
      if (v < -64'sd2147483648) return MIN_I;
      return int'(v);
   endfunction

   // model of one sample: force, outgoing wave, prediction, then delay shift
   function automatic wave_result_type wave_sample(logic [1:0] axis, int vel, int wave_in,
                                                   int pd, int pm, int vm);
      wave_result_type r;
      int              row [0:DEPTH-1];
      longint          s0, s1, acc, ratio;
      longint          x [0:2];
      bit              in_range;
      in_range = axis < NAXES;
      for (int k = 0; k < DEPTH; k++) row[k] = in_range ? wave_hist[axis][k] : 0;
      s0 = longint'(row[0]) + row[1] + row[2] + row[3];
      s1 = longint'(row[4]) + row[5] + row[6] + row[7];
      for (int j = 0; j < 3; j++) begin
         acc = MAT_A[j][0] * pd + MAT_A[j][1] * pm + MAT_A[j][2] * vm;
         acc += (GAIN_B0[j] * s0 + GAIN_B1[j] * s1) >>> 16;
         x[j] = clamp32(round_shr(acc, 24));
      end
      acc = OUT_C[0] * x[0] + OUT_C[1] * x[1] + OUT_C[2] * x[2] + OUT_D * row[0];
      r.pred_v = clamp32(round_shr(acc, 20));
      // ratio below one is used as one
      ratio = (m_ratio < 31'd65536) ? 64'sd65536 : longint'({33'd0, m_ratio});
      acc = longint'({33'd0, m_root}) * wave_in - longint'({33'd0, m_damping}) * vel;
      r.force_v = clamp32(acc / ratio);
      r.wave_v = clamp32(round_shr(longint'({33'd0, m_root}) * vel, 16) - wave_in);
      r.axis = axis;
      if (in_range) begin
         for (int k = DEPTH - 1; k > 0; k--) wave_hist[axis][k] = wave_hist[axis][k-1];
         wave_hist[axis][0] = r.wave_v;
      end
      return r;
   endfunction

   // result side: random stall per word, check against oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected word axis %0d data %h", $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               wave_result_type e;
               e = pending_results.pop_front();
               if (rsp_tuser !== e.axis) begin
                  $display("%0t: axis exp %0d got %0d", $time, e.axis, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[31:0] !== e.force_v) begin
                  $display("%0t: force exp %h got %h", $time, e.force_v, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== e.wave_v) begin
                  $display("%0t: wave exp %h got %h", $time, e.wave_v, rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tdata[95:64] !== e.pred_v) begin
                  $display("%0t: pred exp %h got %h", $time, e.pred_v, rsp_tdata[95:64]);
                  errors++;
               end
            end
            rsp_stall = no_idle ? 0 : $urandom_range(0, 13);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] axis, int vel, int wave_in, int pd, int pm, int vm,
                            bit typed, wave_result_type typed_res);
      int              gap;
      wave_result_type r;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= axis;
      req_tdata <= {vm, pm, pd, wave_in, vel};
      do @(posedge clock); while (!req_tready);
      r = wave_sample(axis, vel, wave_in, pd, pm, vm);
      pending_results.push_back(typed ? typed_res : r);
   endtask

   task automatic write_reg(logic [AXIS_W-1:0] idx, logic [30:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DAMPING: m_damping = value;
         CSR_ROOT:    m_root = value;
         default:     m_ratio = value;
      endcase
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // field values: full random, small, moderate or extreme
   function automatic int draw_value();
      case ($urandom_range(0, 5))
         0, 1: return int'($urandom);
         2: return $urandom_range(0, 2097152) - 1048576;
         3: return $urandom_range(0, 33554432) - 16777216;
         4: return $urandom_range(0, 131072) - 65536;
         default: begin
            case ($urandom_range(0, 3))
               0: return MAX_I;
               1: return MIN_I;
               2: return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [30:0] draw_reg(bit is_ratio);
      case ($urandom_range(0, 3))
         0: return 31'($urandom);
         1: return is_ratio ? 31'($urandom_range(65536, 1048576)) : 31'($urandom_range(0, 1048576));
         2: return is_ratio ? 31'h7FFF_FFFF : 31'($urandom_range(0, 65536));
         default: return is_ratio ? 31'($urandom_range(0, 65535)) : 31'h7FFF_FFFF;
      endcase
   endfunction

   // directed words: zero rows after reset have results readable at once
   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      '{1'b1, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1'b1, 2'd1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1'b1, 2'd3, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1'b0, 2'd0, 65536, 0, 0, 0, 0, 0, 0, 0},
      '{1'b0, 2'd0, 0, 65536, 65536, 0, 0, 0, 0, 0},
      '{1'b0, 2'd2, MAX_I, MIN_I, MAX_I, MIN_I, MAX_I, 0, 0, 0},
      '{1'b0, 2'd2, MIN_I, MAX_I, MIN_I, MAX_I, MIN_I, 0, 0, 0},
      '{1'b0, 2'd1, -1, -1, -1, -1, -1, 0, 0, 0},
      '{1'b0, 2'd1, MAX_I, MAX_I, MAX_I, MAX_I, MAX_I, 0, 0, 0},
      '{1'b0, 2'd3, MIN_I, MIN_I, MIN_I, MIN_I, MIN_I, 0, 0, 0},
      '{1'b0, 2'd0, 32768, -32768, 1, -1, 7, 0, 0, 0},
      '{1'b0, 2'd0, -98304, 131072, 0, 65536, -65536, 0, 0, 0},
      '{1'b0, 2'd2, 1, 0, 0, 0, 0, 0, 0, 0},
      '{1'b0, 2'd3, 655360, -655360, 1000, -1000, 42, 0, 0, 0}
   };

   initial begin
      wave_result_type tr;
      int              n_items;
      errors = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DAMPING;
      csr_wdata = '0;
      m_damping = 31'd655360;
      m_root = 31'd293089;
      m_ratio = 31'd327680;
      for (int a = 0; a < NAXES; a++)
         for (int k = 0; k < DEPTH; k++) wave_hist[a][k] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset values
      for (int i = 0; i < DIR_ROWS; i++) begin
         tr.axis = dir_table[i].axis;
         tr.force_v = dir_table[i].e_force;
         tr.wave_v = dir_table[i].e_wave;
         tr.pred_v = dir_table[i].e_pred;
         send_word(dir_table[i].axis, dir_table[i].vel, dir_table[i].wave_in,
                   dir_table[i].pd, dir_table[i].pm, dir_table[i].vm,
                   dir_table[i].typed, tr);
      end
      drain();

      // register phases: fixed extreme and boundary settings first, then random settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_DAMPING, 31'd0);
               write_reg(CSR_ROOT, 31'd0);
               write_reg(CSR_RATIO, 31'd0);
            end
            1: begin
               write_reg(CSR_DAMPING, 31'h7FFF_FFFF);
               write_reg(CSR_ROOT, 31'h7FFF_FFFF);
               write_reg(CSR_RATIO, 31'h7FFF_FFFF);
            end
            2: begin
               write_reg(CSR_DAMPING, 31'h7FFF_FFFF);
               write_reg(CSR_ROOT, 31'h7FFF_FFFF);
               write_reg(CSR_RATIO, 31'd65536);
            end
            3: begin
               write_reg(CSR_DAMPING, 31'd655360);
               write_reg(CSR_ROOT, 31'd293089);
               write_reg(CSR_RATIO, 31'd65535);
            end
            default: begin
               write_reg(CSR_DAMPING, draw_reg(1'b0));
               write_reg(CSR_ROOT, draw_reg(1'b0));
               write_reg(CSR_RATIO, draw_reg(1'b1));
            end
         endcase
         n_items = (ph < 4) ? 100 : 200;
         for (int i = 0; i < n_items; i++) begin
            logic [1:0] ax;
            // stretches with no idling on either side
            if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            ax = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, NAXES - 1));
            send_word(ax, draw_value(), draw_value(), draw_value(), draw_value(),
                      draw_value(), 1'b0, tr);
         end
         no_idle = 1'b0;
         drain();
      end

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/wvp_pkg.sv
rtl/core/wvp_div.sv
rtl/core/wvp_datapath.sv
rtl/core/wvp_ctrl.sv
rtl/core/wave_variable_predictor.sv
tb/sv/tb_wave_variable_predictor.sv
